[rtl/sapr_pkg.sv]
// ----------------------------------------------------------------------------
// sapr_pkg
// Shared types, constants and codes of the sonar altitude PI regulator.
// ----------------------------------------------------------------------------
package sapr_pkg;

  // Fixed-point format and runaway detector limit
  localparam int FRAC_BITS  = 10;
  localparam int RISE_LIMIT = 20;
  localparam int RISE_SAT   = 31;

  localparam int Q_ONE          = 1 << FRAC_BITS;
  localparam int Q_HALF         = Q_ONE / 2;
  localparam int Q_TENTH        = (Q_ONE + 5) / 10;
  localparam int Q_TWENTIETH    = (Q_ONE + 10) / 20;
  localparam int Q_SIX_TENTHS   = (6 * Q_ONE + 5) / 10;
  localparam int Q_SEVEN_TENTHS = (7 * Q_ONE + 5) / 10;
  localparam int Q_THREE_TENTHS = Q_ONE - Q_SEVEN_TENTHS;

  // Configuration register indexes
  localparam logic [3:0] REG_SET_HEIGHT       = 4'd0;
  localparam logic [3:0] REG_SONAR_MIN        = 4'd1;
  localparam logic [3:0] REG_SONAR_MAX        = 4'd2;
  localparam logic [3:0] REG_ALTITUDE_CEILING = 4'd3;
  localparam logic [3:0] REG_KP_ASCEND        = 4'd4;
  localparam logic [3:0] REG_KI_ASCEND        = 4'd5;
  localparam logic [3:0] REG_KP_DESCEND       = 4'd6;
  localparam logic [3:0] REG_KI_DESCEND       = 4'd7;

  // Status codes
  localparam logic [1:0] STAT_NORMAL  = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_CEILING = 2'd2;
  localparam logic [1:0] STAT_RUNAWAY = 2'd3;

  typedef struct packed {
    logic [13:0] set_height;
    logic [13:0] sonar_min;
    logic [13:0] sonar_max;
    logic [17:0] altitude_ceiling;
    logic [10:0] kp_ascend;
    logic [10:0] ki_ascend;
    logic [10:0] kp_descend;
    logic [10:0] ki_descend;
  } cfg_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_EVAL,
    OP_MUL_I,
    OP_INT,
    OP_MUL_KI,
    OP_ADJ,
    OP_GUARD,
    OP_MUL_PREV,
    OP_DAMP
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic sonar_bad;   // sonar outside its window
    logic guard_trip;  // ceiling or runaway ascent forces descent
  } dp_stat_t;

endpackage

[rtl/sapr_ctrl.sv]
// ----------------------------------------------------------------------------
// sapr_ctrl
// Sequencer: steps the datapath through one sample and owns the handshakes.
// ----------------------------------------------------------------------------
module sapr_ctrl
  import sapr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_MUL_I,
    S_INT,
    S_MUL_KI,
    S_ADJ,
    S_GUARD,
    S_MUL_PREV,
    S_DAMP
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;
  logic   finish;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.op = OP_NOP;
    unique case (state_q)
      S_IDLE:     if (in_valid_i) cmd_o.op = OP_LOAD;
      S_EVAL:     if (slot_free) cmd_o.op = OP_EVAL;
      S_MUL_I:    cmd_o.op = OP_MUL_I;
      S_INT:      cmd_o.op = OP_INT;
      S_MUL_KI:   cmd_o.op = OP_MUL_KI;
      S_ADJ:      cmd_o.op = OP_ADJ;
      S_GUARD:    if (slot_free) cmd_o.op = OP_GUARD;
      S_MUL_PREV: cmd_o.op = OP_MUL_PREV;
      S_DAMP:     if (slot_free) cmd_o.op = OP_DAMP;
      default:    cmd_o.op = OP_NOP;
    endcase
  end

  // A word is produced by these three steps only
  assign finish = ((cmd_o.op == OP_EVAL) && stat_i.sonar_bad) ||
                  ((cmd_o.op == OP_GUARD) && stat_i.guard_trip) ||
                  (cmd_o.op == OP_DAMP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE:     if (in_valid_i) state_q <= S_EVAL;
        S_EVAL: begin
          if (slot_free) state_q <= stat_i.sonar_bad ? S_IDLE : S_MUL_I;
        end
        S_MUL_I:    state_q <= S_INT;
        S_INT:      state_q <= S_MUL_KI;
        S_MUL_KI:   state_q <= S_ADJ;
        S_ADJ:      state_q <= S_GUARD;
        S_GUARD: begin
          if (slot_free) state_q <= stat_i.guard_trip ? S_IDLE : S_MUL_PREV;
        end
        S_MUL_PREV: state_q <= S_DAMP;
        S_DAMP:     if (slot_free) state_q <= S_IDLE;
        default:    state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/sapr_dpath.sv]
// ----------------------------------------------------------------------------
// sapr_dpath
// Datapath: one shared multiplier, product and accumulator registers,
// regulator state and the output word register.
// ----------------------------------------------------------------------------
module sapr_dpath
  import sapr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  dp_cmd_t            cmd_i,
  output dp_stat_t           stat_o,
  input  logic signed [18:0] altitude_i,
  input  logic signed [18:0] sonar_dist_i,
  output logic signed [11:0] climb_rate_o,
  output logic [1:0]         status_o
);

  localparam logic signed [18:0] R_ONE   = 19'(Q_ONE);
  localparam logic signed [18:0] R_MHALF = 19'(-Q_HALF);
  localparam logic signed [18:0] R_SIX   = 19'(Q_SIX_TENTHS);
  localparam logic signed [19:0] I_ONE   = 20'(Q_ONE);
  localparam logic signed [19:0] I_MONE  = 20'(-Q_ONE);

  // Input sample
  logic signed [18:0] alt_q;
  logic signed [18:0] son_q;
  // Work registers
  logic signed [15:0] err_q;
  logic signed [27:0] prod_q;
  logic signed [27:0] acc_q;
  logic signed [11:0] adj_q;
  // Regulator state
  logic signed [11:0] integ_q;
  logic [4:0]         rise_q;
  logic signed [19:0] prev_alt_q;
  logic signed [11:0] prev_out_q;
  // Output word
  logic signed [11:0] rate_q;
  logic [1:0]         stat_q;

  logic signed [15:0] err_c;
  logic               ascend;
  logic               small_err;
  logic signed [15:0] mul_a;
  logic signed [11:0] mul_b;
  logic signed [27:0] mul_p;
  logic signed [28:0] sum_c;
  logic signed [18:0] sum_rnd;
  logic signed [18:0] prod_rnd;
  logic signed [19:0] integ_sum;
  logic signed [11:0] integ_new;
  logic signed [18:0] adj_hi;
  logic signed [11:0] adj_new;
  logic               over_ceiling;
  logic               rising;
  logic [4:0]         rise_inc;
  logic               runaway;

  // Half-up rounding: floor((x + ONE/2) / ONE)
  function automatic logic signed [18:0] qround(input logic signed [28:0] x);
    logic signed [28:0] y;
    y = x + 29'(Q_HALF);
    return 19'(y >>> FRAC_BITS);
  endfunction

  assign stat_o.sonar_bad =
      (son_q <= $signed({5'b0, cfg_i.sonar_min})) ||
      (son_q >  $signed({5'b0, cfg_i.sonar_max}));

  // Sonar lies in (min, max] here, so it fits in 14 bits
  assign err_c = $signed({2'b0, cfg_i.set_height}) - $signed({2'b0, son_q[13:0]});

  assign ascend    = (err_q > 16'sd0);
  assign small_err = (err_q > 16'(-Q_HALF)) && (err_q < 16'(Q_HALF));

  // Shared multiplier operand selection
  always_comb begin
    mul_a = err_q;
    mul_b = 12'(Q_TENTH);
    unique case (cmd_i.op)
      OP_INT: begin
        mul_a = err_q;
        mul_b = ascend ? {1'b0, cfg_i.kp_ascend} : {1'b0, cfg_i.kp_descend};
      end
      OP_MUL_KI: begin
        mul_a = 16'(integ_q);
        mul_b = ascend ? {1'b0, cfg_i.ki_ascend} : {1'b0, cfg_i.ki_descend};
      end
      OP_GUARD: begin
        mul_a = 16'(adj_q);
        mul_b = 12'(Q_SEVEN_TENTHS);
      end
      OP_MUL_PREV: begin
        mul_a = 16'(prev_out_q);
        mul_b = 12'(Q_THREE_TENTHS);
      end
      default: begin
        mul_a = err_q;
        mul_b = 12'(Q_TENTH);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign sum_c    = 29'(acc_q) + 29'(prod_q);
  assign sum_rnd  = qround(sum_c);
  assign prod_rnd = qround(29'(prod_q));

  // Integral with anti-windup clamp
  assign integ_sum = 20'(prod_rnd) + 20'(integ_q);
  always_comb begin
    if (!small_err) begin
      integ_new = '0;
    end else if (integ_sum > I_ONE) begin
      integ_new = 12'(I_ONE);
    end else if (integ_sum < I_MONE) begin
      integ_new = 12'(I_MONE);
    end else begin
      integ_new = 12'(integ_sum);
    end
  end

  // PI sum clamp; wider ceiling when far below target
  assign adj_hi = (err_q > 16'(Q_ONE)) ? R_ONE : R_SIX;
  always_comb begin
    if (sum_rnd < R_MHALF) begin
      adj_new = 12'(R_MHALF);
    end else if (sum_rnd > adj_hi) begin
      adj_new = 12'(adj_hi);
    end else begin
      adj_new = 12'(sum_rnd);
    end
  end

  // Ceiling and runaway ascent guard
  assign over_ceiling = (alt_q > $signed({1'b0, cfg_i.altitude_ceiling}));
  assign rising = (21'(alt_q) > 21'(prev_alt_q) + 21'(Q_TWENTIETH)) && (adj_q > 12'sd0);
  assign rise_inc = (rise_q == 5'(RISE_SAT)) ? rise_q : rise_q + 5'd1;
  assign runaway = rising && (32'(rise_inc) > RISE_LIMIT);
  assign stat_o.guard_trip = over_ceiling || runaway;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      rise_q     <= '0;
      prev_alt_q <= '0;
      prev_out_q <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_INT: integ_q <= integ_new;
        OP_GUARD: begin
          if (over_ceiling) begin
            integ_q <= '0;
          end else if (rising) begin
            if (runaway) begin
              rise_q  <= '0;
              integ_q <= '0;
            end else begin
              rise_q     <= rise_inc;
              prev_alt_q <= 20'(alt_q);
            end
          end else begin
            rise_q     <= '0;
            prev_alt_q <= 20'(alt_q);
          end
        end
        OP_DAMP: prev_out_q <= 12'(sum_rnd);
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        alt_q <= altitude_i;
        son_q <= sonar_dist_i;
      end
      OP_EVAL: begin
        err_q <= err_c;
        if (stat_o.sonar_bad) begin
          rate_q <= '0;
          stat_q <= STAT_INVALID;
        end
      end
      OP_MUL_I: prod_q <= mul_p;
      OP_INT:   prod_q <= mul_p;
      OP_MUL_KI: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      OP_ADJ: adj_q <= adj_new;
      OP_GUARD: begin
        prod_q <= mul_p;
        if (over_ceiling) begin
          rate_q <= 12'(-Q_HALF);
          stat_q <= STAT_CEILING;
        end else if (runaway) begin
          rate_q <= 12'(-Q_HALF);
          stat_q <= STAT_RUNAWAY;
        end
      end
      OP_MUL_PREV: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      OP_DAMP: begin
        rate_q <= 12'(sum_rnd);
        stat_q <= STAT_NORMAL;
      end
      default: ;
    endcase
  end

  assign climb_rate_o = rate_q;
  assign status_o     = stat_q;

endmodule

[rtl/sonar_altitude_pi_regulator.sv]
// ----------------------------------------------------------------------------
// sonar_altitude_pi_regulator
// PI climb-rate regulator with anti-windup, ceiling cutoff and runaway guard.
//
//   channel | signals                                        | direction
//   in      | in_valid_i, in_ready_o, altitude_i, sonar_dist_i | sample in
//   out     | out_valid_o, out_ready_i, climb_rate_o, status_o | command out
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | register write
//
// One sample at a time through a single shared 16x12 multiplier.
// A sample ends at the sonar check when the sonar is invalid, at the guard
// step on a ceiling or runaway trip and at the damping step otherwise; ready
// returns with word valid.
// A word waiting in the output register does not block the next accept;
// the sonar check, the guard and the damping step hold while it is untaken.
// Reset clears controller state and regulator state and loads register
// defaults; cfg writes are taken every cycle.
// ----------------------------------------------------------------------------
module sonar_altitude_pi_regulator
  import sapr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [18:0] altitude_i,
  input  logic signed [18:0] sonar_dist_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [11:0] climb_rate_o,
  output logic [1:0]         status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [17:0]        cfg_data_i
);

  cfg_t     cfg_q;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  // Register file; indexes beyond the list drop the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_height       <= 14'd2048;
      cfg_q.sonar_min        <= 14'd102;
      cfg_q.sonar_max        <= 14'd10240;
      cfg_q.altitude_ceiling <= 18'd8192;
      cfg_q.kp_ascend        <= 11'd870;
      cfg_q.ki_ascend        <= 11'd154;
      cfg_q.kp_descend       <= 11'd461;
      cfg_q.ki_descend       <= 11'd102;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SET_HEIGHT:       cfg_q.set_height       <= cfg_data_i[13:0];
        REG_SONAR_MIN:        cfg_q.sonar_min        <= cfg_data_i[13:0];
        REG_SONAR_MAX:        cfg_q.sonar_max        <= cfg_data_i[13:0];
        REG_ALTITUDE_CEILING: cfg_q.altitude_ceiling <= cfg_data_i;
        REG_KP_ASCEND:        cfg_q.kp_ascend        <= cfg_data_i[10:0];
        REG_KI_ASCEND:        cfg_q.ki_ascend        <= cfg_data_i[10:0];
        REG_KP_DESCEND:       cfg_q.kp_descend       <= cfg_data_i[10:0];
        REG_KI_DESCEND:       cfg_q.ki_descend       <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  sapr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sapr_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .altitude_i   (altitude_i),
    .sonar_dist_i (sonar_dist_i),
    .climb_rate_o (climb_rate_o),
    .status_o     (status_o)
  );

endmodule
